// ===== hw/rtl/lmbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmbf_pkg
// Shared types and constants for the bit-plane frame buffer: operation codes,
// controller states, control and status bundles and the gamma table.
// ----------------------------------------------------------------------------
package lmbf_pkg;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SETUP,
        ST_CLEAR,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_READ_RD,
        ST_RESP
    } lmbf_state_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic clr_step;
        logic mem_rd;
        logic mem_wr;
        logic respond;
    } lmbf_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       hit;
        logic       clr_last;
        logic       plane_last;
    } lmbf_status_t;

    localparam logic [7:0] GAMMA_LUT [0:255] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3,
        8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd4,
        8'd4, 8'd5, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6, 8'd6, 8'd7,
        8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd10,
        8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd12, 8'd12, 8'd13, 8'd13, 8'd13,
        8'd14, 8'd14, 8'd15, 8'd15, 8'd16, 8'd16, 8'd17, 8'd17, 8'd18, 8'd18,
        8'd19, 8'd19, 8'd20, 8'd20, 8'd21, 8'd21, 8'd22, 8'd22, 8'd23, 8'd24,
        8'd24, 8'd25, 8'd25, 8'd26, 8'd27, 8'd27, 8'd28, 8'd29, 8'd29, 8'd30,
        8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd35, 8'd36, 8'd37, 8'd38,
        8'd39, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47,
        8'd48, 8'd49, 8'd50, 8'd50, 8'd51, 8'd52, 8'd54, 8'd55, 8'd56, 8'd57,
        8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd66, 8'd67, 8'd68,
        8'd69, 8'd70, 8'd72, 8'd73, 8'd74, 8'd75, 8'd77, 8'd78, 8'd79, 8'd81,
        8'd82, 8'd83, 8'd85, 8'd86, 8'd87, 8'd89, 8'd90, 8'd92, 8'd93, 8'd95,
        8'd96, 8'd98, 8'd99, 8'd101, 8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110,
        8'd112, 8'd114, 8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
        8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142, 8'd144, 8'd146,
        8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158, 8'd160, 8'd162, 8'd164, 8'd167,
        8'd169, 8'd171, 8'd173, 8'd175, 8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189,
        8'd191, 8'd193, 8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
        8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233, 8'd236, 8'd239,
        8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
    };

endpackage
`default_nettype wire

// ===== hw/rtl/led_matrix_bitplane_framebuffer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// draw: one store read and one write per plane
// clear: all PLANES*(PANEL_ROWS/2)*PANEL_COLS store words are zeroed, one word a cycle
// next start is taken in the cycle done is high; results cannot be held off
// after reset the store is swept to zero, all PLANES*(PANEL_ROWS/2)*PANEL_COLS
// words, with busy high throughout (8192 words at the defaults)
// ----------------------------------------------------------------------------
// led_matrix_bitplane_framebuffer_core
// Bit-plane frame store for a split-scan RGB LED panel with gamma correction.
// ----------------------------------------------------------------------------
module led_matrix_bitplane_framebuffer_core #(
    parameter int PANEL_ROWS = 32,
    parameter int PANEL_COLS = 64,
    parameter int PLANES     = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [23:0] rgb,
    input  wire logic [6:0]  col,
    input  wire logic [5:0]  row,
    input  wire logic [2:0]  plane,
    input  wire logic [9:0]  word_index,
    output logic             done,
    output logic             accepted,
    output logic [10:0]      word
);
    import lmbf_pkg::*;

    lmbf_cmd_t    cmd;
    lmbf_status_t status;

    lmbf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lmbf_dp #(
        .PANEL_ROWS (PANEL_ROWS),
        .PANEL_COLS (PANEL_COLS),
        .PLANES     (PLANES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .op         (op),
        .rgb        (rgb),
        .col        (col),
        .row        (row),
        .plane      (plane),
        .word_index (word_index),
        .done       (done),
        .accepted   (accepted),
        .word       (word)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/lmbf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmbf_ctrl
// Sequencer for the frame buffer: reset clearing pass, command capture,
// per-plane read-modify-write, clear sweep, word read and result strobe.
// ----------------------------------------------------------------------------
module lmbf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire lmbf_pkg::lmbf_status_t status,
    output lmbf_pkg::lmbf_cmd_t        cmd,
    output logic                       busy
);
    import lmbf_pkg::*;

    lmbf_state_t state_reg;
    lmbf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_INIT:
            begin
                // store swept to zero after reset
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
                if (start)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
                case (status.op)
                    OP_DRAW:  state_next = status.hit ? ST_DRAW_RD : ST_RESP;
                    OP_CLEAR: state_next = ST_CLEAR;
                    OP_READ:  state_next = status.hit ? ST_READ_RD : ST_RESP;
                    default:  state_next = ST_RESP;
                endcase
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_DRAW_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR:
            begin
                cmd.mem_wr = 1'b1;
                state_next = status.plane_last ? ST_RESP : ST_DRAW_RD;
            end
            ST_READ_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                cmd.respond = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lmbf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmbf_dp
// Datapath for the frame buffer: command registers, gamma lookup, bounds
// checks, address generation, the single-port colour store and result words.
// ----------------------------------------------------------------------------
module lmbf_dp #(
    parameter int PANEL_ROWS = 32,
    parameter int PANEL_COLS = 64,
    parameter int PLANES     = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lmbf_pkg::lmbf_cmd_t   cmd,
    output lmbf_pkg::lmbf_status_t     status,
    input  wire logic [1:0]            op,
    input  wire logic [23:0]           rgb,
    input  wire logic [6:0]            col,
    input  wire logic [5:0]            row,
    input  wire logic [2:0]            plane,
    input  wire logic [9:0]            word_index,
    output logic                       done,
    output logic                       accepted,
    output logic [10:0]                word
);
    import lmbf_pkg::*;

    localparam int HALF_ROWS   = PANEL_ROWS / 2;
    localparam int PLANE_WORDS = HALF_ROWS * PANEL_COLS;
    localparam int STORE_WORDS = PLANES * PLANE_WORDS;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    logic [5:0] colour_mem [0:STORE_WORDS-1];

    // captured command
    logic [1:0]    op_reg;
    logic          hit_reg;
    logic          bottom_reg;
    logic [5:0]    rih_reg;
    logic [6:0]    col_reg;
    logic [2:0]    plane_in_reg;
    logic [9:0]    wi_reg;
    logic [7:0]    r_reg;
    logic [7:0]    g_reg;
    logic [7:0]    b_reg;
    logic [5:0]    rd_data_reg;
    logic [10:0]   word_reg;
    logic [10:0]   word_next;
    logic          accepted_reg;
    logic          done_reg;
    logic [2:0]    pcnt_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;

    logic          bottom_in;
    logic [5:0]    rih_in;
    logic          hit_in;
    logic [AW-1:0] slot;
    logic [AW-1:0] read_addr;
    logic [2:0]    bits;
    logic          mem_we;
    logic [5:0]    mem_wdata;

    always_comb
    begin
        bottom_in = 32'(row) >= HALF_ROWS;
        rih_in    = bottom_in ? (row - 6'(HALF_ROWS)) : row;
        case (op)
            OP_DRAW:  hit_in = (32'(col) < PANEL_COLS) && (32'(row) < PANEL_ROWS)
                               && (32'(rih_in) < HALF_ROWS);
            OP_CLEAR: hit_in = 1'b1;
            OP_READ:  hit_in = (32'(plane) < PLANES) && (32'(word_index) < PLANE_WORDS);
            default:  hit_in = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= op;
            hit_reg      <= hit_in;
            bottom_reg   <= bottom_in;
            rih_reg      <= rih_in;
            col_reg      <= col;
            plane_in_reg <= plane;
            wi_reg       <= word_index;
            r_reg        <= GAMMA_LUT[rgb[23:16]];
            g_reg        <= GAMMA_LUT[rgb[15:8]];
            b_reg        <= GAMMA_LUT[rgb[7:0]];
        end
    end

    // only meaningful once the bounds check has passed, so wrap is harmless
    assign slot      = AW'(rih_reg) * AW'(PANEL_COLS) + AW'(col_reg);
    assign read_addr = AW'(plane_in_reg) * AW'(PLANE_WORDS) + AW'(wi_reg);

    always_comb
    begin
        addr_next = addr_reg;
        if (cmd.setup)
        begin
            case (op_reg)
                OP_DRAW: addr_next = slot;
                OP_READ: addr_next = read_addr;
                default: addr_next = '0;
            endcase
        end
        else if (cmd.clr_step)
        begin
            addr_next = (addr_reg == AW'(STORE_WORDS - 1)) ? '0 : addr_reg + AW'(1);
        end
        else if (cmd.mem_wr)
        begin
            addr_next = addr_reg + AW'(PLANE_WORDS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            pcnt_reg     <= '0;
            done_reg     <= 1'b0;
            accepted_reg <= 1'b0;
        end
        else
        begin
            addr_reg <= addr_next;
            done_reg <= cmd.respond;
            if (cmd.setup)
            begin
                pcnt_reg <= '0;
            end
            else if (cmd.mem_wr)
            begin
                pcnt_reg <= pcnt_reg + 3'd1;
            end
            if (cmd.respond)
            begin
                accepted_reg <= hit_reg;
            end
        end
    end

    // plane bits of the corrected channels, red in the top position
    assign bits      = {r_reg[pcnt_reg], g_reg[pcnt_reg], b_reg[pcnt_reg]};
    assign mem_we    = cmd.clr_step | cmd.mem_wr;
    assign mem_wdata = cmd.clr_step ? 6'd0
                     : (bottom_reg ? {rd_data_reg[5:3], bits} : {bits, rd_data_reg[2:0]});

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            colour_mem[addr_reg] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= colour_mem[addr_reg];
        end
    end

    always_comb
    begin
        word_next = '0;
        if (op_reg == OP_READ && hit_reg)
        begin
            word_next = {rd_data_reg[5:3], rd_data_reg[2:0], 5'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            word_reg <= word_next;
        end
    end

    assign status.op         = op_reg;
    assign status.hit        = hit_reg;
    assign status.clr_last   = addr_reg == AW'(STORE_WORDS - 1);
    assign status.plane_last = pcnt_reg == 3'(PLANES - 1);

    assign done     = done_reg;
    assign accepted = accepted_reg;
    assign word     = word_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/lmbf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmbf_checker
// Port-level checks on command acceptance and the result strobe.
// ----------------------------------------------------------------------------
module lmbf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        accepted,
    input wire logic [10:0] word
);

    // an accepted command always occupies the block next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command");

    // results are separated by at least the setup and response states
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back to back done strobes");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_word_reject: assert property (@(posedge clk) disable iff (!rst_n)
        done && !accepted |-> word == 11'd0)
        else $error("nonzero word on rejection");

    a_word_low: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> word[4:0] == 5'd0)
        else $error("unused word bits set");

endmodule

bind led_matrix_bitplane_framebuffer_core lmbf_checker u_lmbf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .accepted (accepted),
    .word     (word)
);
`default_nettype wire
